>>> design/dmcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmcc_pkg: shared types and constants of the direct-mapped cache controller
// Address split, line geometry, command and status codes, beat payloads.
// ----------------------------------------------------------------------------
package dmcc_pkg;

  localparam int unsigned LINES      = 16;
  localparam int unsigned LINE_BYTES = 8;

  // floor(log2(x)) for x >= 1
  localparam int unsigned OFF_W   = $clog2(LINE_BYTES + 1) - 1;
  localparam int unsigned IDX_W   = $clog2(LINES + 1) - 1;
  localparam int unsigned IDX_AW  = (IDX_W > 0) ? IDX_W : 1;
  localparam int unsigned ENTRIES = 1 << IDX_W;
  localparam int unsigned TAG_W   = 32 - OFF_W - IDX_W;
  localparam int unsigned LINE_W  = 8 * LINE_BYTES;

  localparam logic [31:0] OFF_MASK = 32'((64'd1 << OFF_W) - 64'd1);
  localparam logic [31:0] IDX_MASK = 32'((64'd1 << IDX_W) - 64'd1);

  localparam logic [1:0] FUNC_READ   = 2'd0;
  localparam logic [1:0] FUNC_WRITE  = 2'd1;
  localparam logic [1:0] FUNC_RETURN = 2'd2;

  localparam logic [1:0] STATUS_DONE   = 2'd0;
  localparam logic [1:0] STATUS_REQ    = 2'd1;
  localparam logic [1:0] STATUS_REJECT = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] address;
    logic [7:0]  write_data;
    logic [63:0] line_data;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [7:0]  read_data;
    logic [31:0] mem_address;
    logic        mem_write;
    logic [7:0]  mem_write_data;
  } res_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [LINE_W-1:0] bytes;
  } entry_t;

endpackage
`default_nettype wire

>>> design/direct_mapped_cache_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// direct_mapped_cache_controller: write-through direct-mapped cache
// Tag and line store in one synchronous RAM, valid bits in flops, one
// outstanding memory request tracked by a pending flag and address.
// ----------------------------------------------------------------------------
//
//   channel   ports                  direction  qualifier
//   --------  ---------------------  ---------  --------------------------
//   request   start_i, req_i         in         start_i && !busy_o
//   result    done_o, res_o          out        done_o (one cycle, no stall)
//
// For each beat, the accept edge launches the RAM read at the beat's line
// index; the following LOOKUP cycle compares the tag, updates the RAM /
// valid bits / pending state and registers the result. The result shows on
// res_o with done_o in the cycle after LOOKUP, while the next beat may
// already be accepted. The registered RAM read, and holding the next read
// off until the LOOKUP write-back has landed, are why LOOKUP takes no beat.
// Reset clears valid bits, pending state and the FSM; RAM contents stay
// undefined and are only read under a set valid bit. The receiver cannot
// stall; busy_o is high only during LOOKUP.
// ----------------------------------------------------------------------------
module direct_mapped_cache_controller (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire dmcc_pkg::req_t  req_i,
  output logic                 busy_o,
  output logic                 done_o,
  output dmcc_pkg::res_t       res_o
);

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e                       state_q, state_d;
  logic                         pending_q, pending_d;
  logic [31:0]                  pend_addr_q, pend_addr_d;
  logic [dmcc_pkg::ENTRIES-1:0] valid_q, valid_d;
  dmcc_pkg::res_t               res_q, res_d;
  logic                         done_q, done_d;

  dmcc_pkg::req_t               req_q;
  dmcc_pkg::entry_t             rd_q;
  dmcc_pkg::entry_t             mem [dmcc_pkg::ENTRIES];

  logic                         accept;
  logic [dmcc_pkg::IDX_AW-1:0]  rd_idx;
  logic [dmcc_pkg::IDX_AW-1:0]  req_idx;
  logic [dmcc_pkg::IDX_AW-1:0]  pend_idx;
  logic [dmcc_pkg::TAG_W-1:0]   req_tag;
  logic [dmcc_pkg::TAG_W-1:0]   pend_tag;
  logic [dmcc_pkg::LINE_W-1:0]  fill_line;
  logic                         mem_we;
  dmcc_pkg::entry_t             wr_entry;

  // Pick byte (offset mod 8) out of a line.
  function automatic logic [7:0] pick_byte(logic [dmcc_pkg::LINE_W-1:0] line,
                                           logic [31:0] addr);
    logic [63:0] wide;
    logic [2:0]  off;
    begin
      wide = 64'(line);
      off  = 3'(addr & dmcc_pkg::OFF_MASK);
      pick_byte = 8'(wide >> {off, 3'b000});
    end
  endfunction

  assign accept   = start_i && (state_q == ST_IDLE);
  assign busy_o   = (state_q == ST_LOOKUP);
  assign done_o   = done_q;
  assign res_o    = res_q;

  // Address split: index and tag of the incoming, held and pending addresses.
  assign rd_idx   = dmcc_pkg::IDX_AW'((req_i.address >> dmcc_pkg::OFF_W) & dmcc_pkg::IDX_MASK);
  assign req_idx  = dmcc_pkg::IDX_AW'((req_q.address >> dmcc_pkg::OFF_W) & dmcc_pkg::IDX_MASK);
  assign pend_idx = dmcc_pkg::IDX_AW'((pend_addr_q >> dmcc_pkg::OFF_W) & dmcc_pkg::IDX_MASK);
  assign req_tag  = dmcc_pkg::TAG_W'(req_q.address >> (dmcc_pkg::OFF_W + dmcc_pkg::IDX_W));
  assign pend_tag = dmcc_pkg::TAG_W'(pend_addr_q >> (dmcc_pkg::OFF_W + dmcc_pkg::IDX_W));

  // Memory keeps only LINE_BYTES bytes of a returned line.
  assign fill_line      = dmcc_pkg::LINE_W'(req_q.line_data);
  assign wr_entry.tag   = pend_tag;
  assign wr_entry.bytes = fill_line;

  // Line store: read launched on accept, write at the end of LOOKUP. The two
  // never fall on the same edge, so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[pend_idx] <= wr_entry;
    end
    if (accept) begin
      rd_q <= mem[rd_idx];
    end
  end

  // Hold the accepted beat for LOOKUP.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  // Tag check and state update for the held beat.
  always_comb begin
    state_d     = state_q;
    pending_d   = pending_q;
    pend_addr_d = pend_addr_q;
    valid_d     = valid_q;
    res_d       = '0;
    done_d      = 1'b0;
    mem_we      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d      = ST_IDLE;
        done_d       = 1'b1;
        res_d.status = dmcc_pkg::STATUS_REJECT;
        unique case (req_q.func)
          dmcc_pkg::FUNC_READ: begin
            if (!pending_q) begin
              if (valid_q[req_idx] && (rd_q.tag == req_tag)) begin
                res_d.status    = dmcc_pkg::STATUS_DONE;
                res_d.hit       = 1'b1;
                res_d.read_data = pick_byte(rd_q.bytes, req_q.address);
              end else begin
                res_d.status      = dmcc_pkg::STATUS_REQ;
                res_d.mem_address = req_q.address;
                pending_d         = 1'b1;
                pend_addr_d       = req_q.address;
              end
            end
          end
          dmcc_pkg::FUNC_WRITE: begin
            if (!pending_q) begin
              res_d.status         = dmcc_pkg::STATUS_REQ;
              res_d.mem_address    = req_q.address;
              res_d.mem_write      = 1'b1;
              res_d.mem_write_data = req_q.write_data;
              pending_d            = 1'b1;
              pend_addr_d          = req_q.address;
            end
          end
          dmcc_pkg::FUNC_RETURN: begin
            if (pending_q) begin
              // Install the line and finish the pending access.
              mem_we            = 1'b1;
              valid_d[pend_idx] = 1'b1;
              pending_d         = 1'b0;
              res_d.status      = dmcc_pkg::STATUS_DONE;
              res_d.read_data   = pick_byte(fill_line, pend_addr_q);
            end
          end
          default: begin
            // Unused code: reject, drop the beat.
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pending_q   <= 1'b0;
      pend_addr_q <= '0;
      valid_q     <= '0;
      res_q       <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      pending_q   <= pending_d;
      pend_addr_q <= pend_addr_d;
      valid_q     <= valid_d;
      res_q       <= res_d;
      done_q      <= done_d;
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/tb_direct_mapped_cache_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_direct_mapped_cache_controller: self-checking bench for the cache
// A shadow copy of the valid bits, tags, line bytes and the pending request
// predicts one reply per accepted beat. A directed sequence is followed by
// random traffic built mostly from well-formed miss/fill pairs. Every reply
// is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_direct_mapped_cache_controller;
  import dmcc_pkg::*;

  localparam int unsigned NUM_RANDOM   = 1000;
  localparam int unsigned QUIET_TAIL   = 150;    // final beats sent back to back
  localparam int unsigned DRAIN_CYCLES = 8;      // a reply is registered after its beat's LOOKUP
  localparam int unsigned CYCLE_LIMIT  = 200000; // watchdog bound on the run

  // --------------------------------------------------------------------------
  // Shadow cache: predicts the reply to each accepted beat and checks replies.
  // --------------------------------------------------------------------------
  class reply_shadow;
    logic              valid_q [ENTRIES];
    logic [31:0]       tag_q   [ENTRIES];
    logic [LINE_W-1:0] bytes_q [ENTRIES];
    bit                pending;
    logic [31:0]       pending_addr;
    res_t              replies_due [$];
    int unsigned       errors, n_checked;
    int unsigned       n_hits, n_misses, n_writes, n_fills, n_rejects;

    function new();
      foreach (valid_q[i]) valid_q[i] = 1'b0;
      pending      = 1'b0;
      pending_addr = '0;
      errors       = 0;
      n_checked    = 0;
      n_hits       = 0;
      n_misses     = 0;
      n_writes     = 0;
      n_fills      = 0;
      n_rejects    = 0;
    endfunction

    function int unsigned line_of(logic [31:0] a);
      return int'((a >> OFF_W) & IDX_MASK);
    endfunction

    function logic [31:0] tag_of(logic [31:0] a);
      return a >> (OFF_W + IDX_W);
    endfunction

    function logic [7:0] byte_at(logic [LINE_W-1:0] line, logic [31:0] a);
      return 8'(line >> (8 * (a & OFF_MASK)));
    endfunction

    function res_t predict_reply(req_t b);
      res_t        r;
      int unsigned idx;
      r        = '0;
      r.status = STATUS_REJECT;
      case (b.func)
        FUNC_READ: begin
          if (!pending) begin
            idx = line_of(b.address);
            if (valid_q[idx] && tag_q[idx] == tag_of(b.address)) begin
              r.status    = STATUS_DONE;
              r.hit       = 1'b1;
              r.read_data = byte_at(bytes_q[idx], b.address);
              n_hits++;
            end else begin
              r.status     = STATUS_REQ;
              r.mem_address = b.address;
              pending      = 1'b1;
              pending_addr = b.address;
              n_misses++;
            end
          end
        end
        FUNC_WRITE: begin
          if (!pending) begin
            r.status         = STATUS_REQ;
            r.mem_address    = b.address;
            r.mem_write      = 1'b1;
            r.mem_write_data = b.write_data;
            pending          = 1'b1;
            pending_addr     = b.address;
            n_writes++;
          end
        end
        FUNC_RETURN: begin
          if (pending) begin
            idx          = line_of(pending_addr);
            valid_q[idx] = 1'b1;
            tag_q[idx]   = tag_of(pending_addr);
            bytes_q[idx] = b.line_data[LINE_W-1:0];
            r.status     = STATUS_DONE;
            r.read_data  = byte_at(bytes_q[idx], pending_addr);
            pending      = 1'b0;
            n_fills++;
          end
        end
        default: ;
      endcase
      if (r.status == STATUS_REJECT) n_rejects++;
      return r;
    endfunction

    function void note_access(req_t b);
      replies_due.push_back(predict_reply(b));
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("t=%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_reply(res_t got);
      res_t want;
      if (replies_due.size() == 0) begin
        errors++;
        $display("t=%0t: reply with nothing expected, expected none, actual %0h",
                 $time, got);
        return;
      end
      want = replies_due.pop_front();
      n_checked++;
      check_field("status",         64'(want.status),         64'(got.status));
      check_field("hit",            64'(want.hit),            64'(got.hit));
      check_field("read_data",      64'(want.read_data),      64'(got.read_data));
      check_field("mem_address",    64'(want.mem_address),    64'(got.mem_address));
      check_field("mem_write",      64'(want.mem_write),      64'(got.mem_write));
      check_field("mem_write_data", 64'(want.mem_write_data), 64'(got.mem_write_data));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni  = 1'b0;
  logic        start_i = 1'b0;
  req_t        req_i   = '0;
  logic        busy_o;
  logic        done_o;
  res_t        res_o;

  reply_shadow shadow;
  logic [31:0] tag_pool [3];
  int unsigned cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  direct_mapped_cache_controller u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .res_o   (res_o)
  );

  // --------------------------------------------------------------------------
  // Beat construction
  // --------------------------------------------------------------------------
  function automatic req_t make_beat(logic [1:0] func, logic [31:0] addr,
                                     logic [7:0] wdata, logic [63:0] line);
    req_t b;
    b.func       = func;
    b.address    = addr;
    b.write_data = wdata;
    b.line_data  = line;
    return b;
  endfunction

  // Fully random payload: fills the request during idle cycles.
  function automatic req_t noise_beat();
    return make_beat(2'($urandom), $urandom, 8'($urandom), {$urandom, $urandom});
  endfunction

  function automatic logic [31:0] compose_addr(logic [31:0] tag, int unsigned idx,
                                               int unsigned off);
    return (tag << (OFF_W + IDX_W)) | ((32'(idx) & IDX_MASK) << OFF_W)
           | (32'(off) & OFF_MASK);
  endfunction

  // Draw most addresses from a small tag pool so that lines get reused and hit;
  // the rest are fully random to exercise every address bit.
  function automatic logic [31:0] pick_address();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return compose_addr(tag_pool[$urandom_range(0, 2)], $urandom_range(0, ENTRIES - 1),
                        $urandom_range(0, LINE_BYTES - 1));
  endfunction

  // --------------------------------------------------------------------------
  // Driver: hold the beat until the block takes it, note it in the shadow,
  // then optionally drop start for a short burst of idle cycles.
  // --------------------------------------------------------------------------
  task automatic send_beat(input req_t b, input bit may_idle);
    int unsigned gap;
    start_i <= 1'b1;
    req_i   <= b;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    shadow.note_access(b);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      start_i <= 1'b0;
      repeat (gap) begin
        // Keep the payload moving while start is low; it must be ignored.
        req_i <= noise_beat();
        @(posedge clk_i);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Reply monitor: a reply lives for exactly one cycle and cannot be stalled.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && done_o !== 1'b0) shadow.check_reply(res_o);
  end

  // Watchdog: end the run if the block stops answering.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d replies still due", cycle_count,
               shadow.replies_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] top_addr;
    int unsigned pick;
    bit          quiet;
    bit          bursty;

    shadow = new();
    foreach (tag_pool[i]) tag_pool[i] = $urandom >> (OFF_W + IDX_W);
    top_addr = 32'hFFFF_FFFF;
    bursty   = 1'b1;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: miss and busy rejects, fills, hits, extremes, conflict eviction.
    send_beat(make_beat(FUNC_READ, 32'h0, 8'h00, 64'h0), 1'b1);           // miss
    send_beat(make_beat(FUNC_READ, 32'h0, 8'h00, 64'h0), 1'b1);           // busy
    send_beat(make_beat(FUNC_WRITE, 32'h8, 8'hFF, 64'h0), 1'b1);          // busy
    send_beat(make_beat(2'd3, 32'h0, 8'h00, 64'h0), 1'b1);                // unused code
    send_beat(make_beat(FUNC_RETURN, 32'h0, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF), 1'b1);
    send_beat(make_beat(FUNC_READ, 32'h5, 8'h00, 64'h0), 1'b1);           // hit
    send_beat(make_beat(FUNC_RETURN, 32'h0, 8'h00, 64'h1234), 1'b1);      // unexpected
    send_beat(make_beat(2'd3, 32'hFFFF_FFFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF), 1'b1);
    send_beat(make_beat(FUNC_READ, top_addr, 8'h00, 64'h0), 1'b1);        // miss, top
    send_beat(make_beat(FUNC_RETURN, 32'h0, 8'h00, 64'h0123_4567_89AB_CDEF), 1'b1);
    send_beat(make_beat(FUNC_READ, top_addr & ~OFF_MASK, 8'h00, 64'h0), 1'b1);
    send_beat(make_beat(FUNC_WRITE, top_addr, 8'hFF, 64'h0), 1'b1);
    send_beat(make_beat(FUNC_RETURN, 32'hFFFF_FFFF, 8'hFF, 64'h0), 1'b1);
    send_beat(make_beat(FUNC_READ, top_addr, 8'h00, 64'h0), 1'b1);        // hit, zero
    send_beat(make_beat(FUNC_WRITE, 32'h0, 8'h00, 64'h0), 1'b1);
    send_beat(make_beat(FUNC_RETURN, 32'h0, 8'h00, 64'h8000_0000_0000_0001), 1'b1);
    send_beat(make_beat(FUNC_READ, compose_addr(32'd1, 0, 3), 8'h00, 64'h0), 1'b1);
    send_beat(make_beat(FUNC_RETURN, 32'h0, 8'h00, {$urandom, $urandom}), 1'b1);
    send_beat(make_beat(FUNC_READ, 32'h7, 8'h00, 64'h0), 1'b1);           // evicted
    send_beat(make_beat(FUNC_RETURN, 32'h0, 8'h00, {$urandom, $urandom}), 1'b1);
    send_beat(make_beat(FUNC_READ, compose_addr(32'd1, 0, 0), 8'h00, 64'h0), 1'b1);

    // Random: mostly access/fill pairs with random content, some noise.
    for (int unsigned n = 0; n < NUM_RANDOM; n++) begin
      quiet = (n >= NUM_RANDOM - QUIET_TAIL);
      // Alternate stretches with and without idle bursts.
      if (n % 64 == 0) bursty = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 49) == 0) tag_pool[$urandom_range(0, 2)] =
          $urandom >> (OFF_W + IDX_W);
      pick = $urandom_range(0, 19);
      if (shadow.pending) begin
        if (pick < 16)
          send_beat(make_beat(FUNC_RETURN, $urandom, 8'($urandom), {$urandom, $urandom}),
                    bursty && !quiet);
        else if (pick < 18)
          send_beat(make_beat(FUNC_READ, pick_address(), 8'($urandom),
                              {$urandom, $urandom}), bursty && !quiet);
        else if (pick == 18)
          send_beat(make_beat(FUNC_WRITE, pick_address(), 8'($urandom),
                              {$urandom, $urandom}), bursty && !quiet);
        else
          send_beat(make_beat(2'd3, $urandom, 8'($urandom), {$urandom, $urandom}),
                    bursty && !quiet);
      end else begin
        if (pick < 12)
          send_beat(make_beat(FUNC_READ, pick_address(), 8'($urandom),
                              {$urandom, $urandom}), bursty && !quiet);
        else if (pick < 18)
          send_beat(make_beat(FUNC_WRITE, pick_address(), 8'($urandom),
                              {$urandom, $urandom}), bursty && !quiet);
        else if (pick == 18)
          send_beat(make_beat(FUNC_RETURN, $urandom, 8'($urandom), {$urandom, $urandom}),
                    bursty && !quiet);
        else
          send_beat(make_beat(2'd3, $urandom, 8'($urandom), {$urandom, $urandom}),
                    bursty && !quiet);
      end
    end

    // Drain: drop start, wait for every reply, then let the pipeline settle.
    start_i <= 1'b0;
    @(posedge clk_i);
    while (shadow.replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d read hits, %0d read misses, %0d writes, %0d line fills",
             shadow.n_hits, shadow.n_misses, shadow.n_writes, shadow.n_fills);
    $display("and %0d rejected beats; %0d replies checked, %0d field errors",
             shadow.n_rejects, shadow.n_checked, shadow.errors);
    if (shadow.errors == 0 && shadow.replies_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
